@@ src/owtr_pkg.sv @@
// Shared types, constants and the temperature conversion function for the one-wire reader.
`timescale 1ns / 1ps

package owtr_pkg;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESET_PULSE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESET_LEAD    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRESENCE_WAIT = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOT          = 2'd3;
    localparam int CFG_DATA_W = 10;

    localparam logic [9:0] RESET_PULSE_DEFAULT   = 10'd500;
    localparam logic [7:0] RESET_LEAD_DEFAULT    = 8'd72;
    localparam logic [7:0] PRESENCE_WAIT_DEFAULT = 8'd60;
    localparam logic [7:0] SLOT_DEFAULT          = 8'd60;

    // Bus phases.
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RST_LEAD = 3'd1;
    localparam logic [2:0] PH_RST_LOW  = 3'd2;
    localparam logic [2:0] PH_RST_WAIT = 3'd3;
    localparam logic [2:0] PH_RST_POST = 3'd4;
    localparam logic [2:0] PH_WR_SLOT  = 3'd5;
    localparam logic [2:0] PH_WR_RECOV = 3'd6;
    localparam logic [2:0] PH_RD_SLOT  = 3'd7;

    // Steps of the command sequence.
    localparam logic [3:0] STEP_RESET_A    = 4'd0;
    localparam logic [3:0] STEP_SKIP_A     = 4'd1;
    localparam logic [3:0] STEP_CONVERT    = 4'd2;
    localparam logic [3:0] STEP_RESET_B    = 4'd3;
    localparam logic [3:0] STEP_SKIP_B     = 4'd4;
    localparam logic [3:0] STEP_READ_PAD   = 4'd5;
    localparam logic [3:0] STEP_READ_LOW   = 4'd6;
    localparam logic [3:0] STEP_READ_HIGH  = 4'd7;
    localparam logic [3:0] STEP_LAST       = 4'd8;

    // Command bytes.
    localparam logic [7:0] CMD_SKIP_ROM    = 8'hCC;
    localparam logic [7:0] CMD_CONVERT     = 8'h44;
    localparam logic [7:0] CMD_READ_PAD    = 8'hBE;

    localparam logic [15:0] NEG_MASK       = 16'hF800;

    typedef struct packed {
        logic [9:0] reset_pulse;
        logic [7:0] reset_lead;
        logic [7:0] presence_wait;
        logic [7:0] slot;
    } cfg_t;

    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic        presence_level;
        logic [15:0] temperature;
    } res_t;

    // A word whose top five bits are all zero becomes tenths of a degree; otherwise the raw word is kept.
    function automatic logic [15:0] convert_word(input logic [15:0] word);
        logic [15:0] int_x10;
        logic [6:0]  frac_x5;
        begin
            int_x10 = {4'd0, word[15:4]} * 16'd10;
            frac_x5 = {3'd0, word[3:0]} * 7'd5;
            if ((word & NEG_MASK) == 16'd0) begin
                convert_word = int_x10 + {12'd0, frac_x5[6:3]};
            end else begin
                convert_word = word;
            end
        end
    endfunction

endpackage

@@ src/owtr_cfg.sv @@
// Configuration registers of the one-wire reader, with zero lengths read as one.
`timescale 1ns / 1ps

module owtr_cfg
    import owtr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                  cfg
);

    logic [9:0] pulse_reg;
    logic [7:0] lead_reg;
    logic [7:0] wait_reg;
    logic [7:0] slot_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg <= RESET_PULSE_DEFAULT;
            lead_reg  <= RESET_LEAD_DEFAULT;
            wait_reg  <= PRESENCE_WAIT_DEFAULT;
            slot_reg  <= SLOT_DEFAULT;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_RESET_PULSE:   pulse_reg <= cfg_wr_data[9:0];
                CFG_RESET_LEAD:    lead_reg  <= cfg_wr_data[7:0];
                CFG_PRESENCE_WAIT: wait_reg  <= cfg_wr_data[7:0];
                CFG_SLOT:          slot_reg  <= cfg_wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.reset_pulse   = (pulse_reg == 10'd0) ? 10'd1 : pulse_reg;
        cfg.reset_lead    = (lead_reg == 8'd0) ? 8'd1 : lead_reg;
        cfg.presence_wait = (wait_reg == 8'd0) ? 8'd1 : wait_reg;
        cfg.slot          = (slot_reg == 8'd0) ? 8'd1 : slot_reg;
    end

endmodule

@@ src/owtr_core.sv @@
// Bus sequencer of the one-wire reader: state registers and the per-tick next-state logic.
`timescale 1ns / 1ps

module owtr_core
    import owtr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic fire,
    input  logic start_req,
    input  logic line_in,
    input  cfg_t cfg,
    output res_t res
);

    logic [2:0]  phase_reg, phase_next, phase_eff;
    logic [9:0]  tick_reg, tick_next;
    logic [2:0]  bit_reg, bit_next;
    logic [3:0]  step_reg, step_next, step_inc;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  low_reg, low_next;
    logic        pres_reg, pres_next;
    logic [15:0] result_reg, result_next;
    logic [10:0] tick_inc;
    logic        drive, busy, done, step_end;

    always_comb begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bit_next    = bit_reg;
        step_next   = step_reg;
        shift_next  = shift_reg;
        low_next    = low_reg;
        pres_next   = pres_reg;
        result_next = result_reg;
        drive       = 1'b0;
        busy        = 1'b1;
        done        = 1'b0;
        step_end    = 1'b0;
        tick_inc    = {1'b0, tick_reg} + 11'd1;
        step_inc    = step_reg + 4'd1;

        // The tick that takes a start request is already the first lead tick.
        phase_eff = phase_reg;
        if ((phase_reg == PH_IDLE) && start_req) begin
            phase_eff = PH_RST_LEAD;
        end
        phase_next = phase_eff;

        case (phase_eff)
            PH_IDLE: begin
                busy = 1'b0;
            end
            PH_RST_LEAD: begin
                if (tick_inc >= {3'd0, cfg.reset_lead}) begin
                    phase_next = PH_RST_LOW;
                    tick_next  = 10'd0;
                end else begin
                    tick_next = tick_inc[9:0];
                end
            end
            PH_RST_LOW: begin
                drive = 1'b1;
                if (tick_inc >= {1'b0, cfg.reset_pulse}) begin
                    phase_next = PH_RST_WAIT;
                    tick_next  = 10'd0;
                end else begin
                    tick_next = tick_inc[9:0];
                end
            end
            PH_RST_WAIT: begin
                if (tick_inc >= {3'd0, cfg.presence_wait}) begin
                    phase_next = PH_RST_POST;
                    tick_next  = 10'd0;
                end else begin
                    tick_next = tick_inc[9:0];
                end
            end
            PH_RST_POST: begin
                if (tick_reg == 10'd0) begin
                    pres_next = line_in;
                end
                if (tick_inc >= {3'd0, cfg.presence_wait}) begin
                    step_end = 1'b1;
                end else begin
                    tick_next = tick_inc[9:0];
                end
            end
            PH_WR_SLOT: begin
                drive = (tick_reg == 10'd0) ? 1'b1 : ~shift_reg[0];
                if (tick_reg >= {2'd0, cfg.slot}) begin
                    shift_next = {1'b0, shift_reg[7:1]};
                    tick_next  = 10'd0;
                    bit_next   = bit_reg + 3'd1;
                    if (bit_reg == 3'd7) begin
                        phase_next = PH_WR_RECOV;
                    end
                end else begin
                    tick_next = tick_inc[9:0];
                end
            end
            PH_WR_RECOV: begin
                if (tick_inc >= {3'd0, cfg.slot}) begin
                    step_end = 1'b1;
                end else begin
                    tick_next = tick_inc[9:0];
                end
            end
            PH_RD_SLOT: begin
                if (tick_reg == 10'd0) begin
                    drive = 1'b1;
                end
                if (tick_reg == 10'd1) begin
                    shift_next = {line_in, shift_reg[7:1]};
                end
                if (tick_reg >= {2'd0, cfg.slot}) begin
                    tick_next = 10'd0;
                    bit_next  = bit_reg + 3'd1;
                    if (bit_reg == 3'd7) begin
                        step_end = 1'b1;
                    end
                end else begin
                    tick_next = tick_inc[9:0];
                end
            end
            default: begin
                phase_next = PH_IDLE;
                busy       = 1'b0;
            end
        endcase

        if (step_end) begin
            if (step_reg == STEP_READ_LOW) begin
                low_next = shift_next;
            end
            tick_next = 10'd0;
            bit_next  = 3'd0;
            if (step_reg >= STEP_LAST) begin
                result_next = convert_word({shift_next, low_next});
                phase_next  = PH_IDLE;
                step_next   = STEP_RESET_A;
                done        = 1'b1;
            end else begin
                step_next = step_inc;
                case (step_inc)
                    STEP_SKIP_A, STEP_SKIP_B: begin
                        shift_next = CMD_SKIP_ROM;
                        phase_next = PH_WR_SLOT;
                    end
                    STEP_CONVERT: begin
                        shift_next = CMD_CONVERT;
                        phase_next = PH_WR_SLOT;
                    end
                    STEP_READ_PAD: begin
                        shift_next = CMD_READ_PAD;
                        phase_next = PH_WR_SLOT;
                    end
                    STEP_READ_LOW, STEP_READ_HIGH: begin
                        shift_next = 8'd0;
                        phase_next = PH_RD_SLOT;
                    end
                    default: begin
                        phase_next = PH_RST_LEAD;
                    end
                endcase
            end
        end

        res.drive_low      = drive;
        res.busy_res       = busy;
        res.done_res       = done;
        res.presence_level = pres_next;
        res.temperature    = result_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= 10'd0;
            bit_reg    <= 3'd0;
            step_reg   <= STEP_RESET_A;
            shift_reg  <= 8'd0;
            low_reg    <= 8'd0;
            pres_reg   <= 1'b1;
            result_reg <= 16'd0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            bit_reg    <= bit_next;
            step_reg   <= step_next;
            shift_reg  <= shift_next;
            low_reg    <= low_next;
            pres_reg   <= pres_next;
            result_reg <= result_next;
        end
    end

    a_idle_counters_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |->
            (tick_reg == 10'd0 && bit_reg == 3'd0 && step_reg == STEP_RESET_A))
        else $error("idle phase with nonzero counters");

    a_done_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.done_res) |=> (phase_reg == PH_IDLE))
        else $error("sequence finished but phase did not return to idle");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEP_LAST)
        else $error("command step beyond the last step");

    a_drive_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.drive_low) |-> res.busy_res)
        else $error("bus driven low while no sequence runs");

    a_start_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && phase_reg == PH_IDLE && start_req) |=> (phase_reg != PH_IDLE))
        else $error("start request from idle was not taken");

endmodule

@@ src/one_wire_temperature_reader.sv @@
// Top level of the one-wire temperature reader: input register, sequencer and result register.
`timescale 1ns / 1ps

// Each input item is one microsecond tick of bus time and yields exactly one result item
// that carries the bus drive, status flags and the latest temperature. A start request
// from idle runs reset, skip-ROM, convert, reset, skip-ROM, read scratchpad, two read
// bytes and a final reset; no conversion wait is inserted. The block takes one item per
// clock cycle: the input register feeds the sequencer, whose combinational next-state
// logic loads the result register, so each result is registered after its item has passed
// the input register, and the input side keeps flowing as long as results are taken.
// The user must write the timing registers through the configuration port only while no
// sequence runs and no item is in flight; the block itself does not enforce this.

module one_wire_temperature_reader
    import owtr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // start_req, line_in, zero fill
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata   // drive_low, busy_res, done_res,
                                                 // presence_level, temperature[15:0], zero fill
);

    cfg_t cfg;
    res_t res;
    res_t out_reg;
    logic in_valid_reg, in_valid_next;
    logic in_start_reg;
    logic in_line_reg;
    logic out_valid_reg, out_valid_next;
    logic fire;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_axis_tready) begin
            in_valid_next = s_axis_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_start_reg <= s_axis_tdata[0];
            in_line_reg  <= s_axis_tdata[1];
        end
        if (fire) begin
            out_reg <= res;
        end
    end

    owtr_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    owtr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .start_req (in_start_reg),
        .line_in   (in_line_reg),
        .cfg       (cfg),
        .res       (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_reg.temperature, out_reg.presence_level,
                            out_reg.done_res, out_reg.busy_res, out_reg.drive_low};

endmodule
